/* sv/nmea_field_extractor_core_defines.svh */
// Assertion macros shared by the NMEA field extractor modules
`ifndef NMEA_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define NMEA_FIELD_EXTRACTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define NFE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("nfe: invariant violated");
`define NFE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfe: implication violated");
`else
`define NFE_ASSERT_ALWAYS(lbl, cond)
`define NFE_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

/* sv/nfe_pkg.sv */
// Types, constants and slot mapping for the NMEA field extractor
package nfe_pkg;

    localparam logic [3:0] FIELD_CAP   = 4'd12;
    localparam logic [3:0] NO_SLOT     = 4'd15;
    localparam logic [3:0] FIELD_MAX   = 4'd15;
    localparam logic [2:0] POS_KIND    = 3'd4;
    localparam logic [2:0] POS_MAX     = 3'd5;
    localparam logic [7:0] CHAR_M      = 8'h4D;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RMC  = 2'd1,
        KIND_GGA  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       sentence_start;
    } nfe_item_t;

    typedef struct packed {
        logic [3:0] slot;
        logic [3:0] offset;
        logic [7:0] char_out;
        logic       is_end;
        logic [3:0] length;
    } nfe_result_t;

    function automatic logic [3:0] slot_of(kind_t kind, logic [3:0] field);
        logic [3:0] s;
        s = NO_SLOT;
        unique case (kind)
            KIND_RMC:
            begin
                if (field >= 4'd1 && field <= 4'd6)
                begin
                    s = field - 4'd1;
                end
                else if (field == 4'd9)
                begin
                    s = 4'd6;
                end
            end
            KIND_GGA:
            begin
                if (field == 4'd6)
                begin
                    s = 4'd7;
                end
                else if (field == 4'd7)
                begin
                    s = 4'd8;
                end
            end
            default:
            begin
                s = NO_SLOT;
            end
        endcase
        return s;
    endfunction

endpackage

/* sv/nfe_in_stage.sv */
// Input register of the NMEA field extractor
module nfe_in_stage
    import nfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  nfe_item_t  item,
    input  logic       advance,
    output logic       full,
    output nfe_item_t  held
);

    logic      full_reg;
    logic      full_next;
    nfe_item_t item_reg;
    logic      accept;

    assign in_stall = full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign full = full_reg;
    assign held = item_reg;

endmodule

/* sv/nfe_decode.sv */
// Sentence state and per-character field decision
`include "nmea_field_extractor_core_defines.svh"
module nfe_decode
    import nfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  nfe_item_t   item,
    output logic        res_valid,
    output nfe_result_t res
);

    logic [2:0] byte_position_reg;
    logic [2:0] byte_position_next;
    kind_t      sentence_kind_reg;
    kind_t      sentence_kind_next;
    logic [3:0] field_number_reg;
    logic [3:0] field_number_next;
    logic [3:0] field_offset_reg;
    logic [3:0] field_offset_next;

    logic [2:0] pos;
    kind_t      kind0;
    logic [3:0] fnum0;
    logic [3:0] foff0;
    logic [3:0] slot;
    logic       is_comma;

    always_comb
    begin
        pos   = item.sentence_start ? 3'd0 : byte_position_reg;
        kind0 = item.sentence_start ? KIND_NONE : sentence_kind_reg;
        fnum0 = item.sentence_start ? 4'd0 : field_number_reg;
        foff0 = item.sentence_start ? 4'd0 : field_offset_reg;

        byte_position_next = (pos < POS_MAX) ? pos + 3'd1 : pos;

        sentence_kind_next = kind0;
        if (pos == POS_KIND)
        begin
            if (item.char_in == CHAR_M)
            begin
                sentence_kind_next = KIND_RMC;
            end
            else if (item.char_in == CHAR_G)
            begin
                sentence_kind_next = KIND_GGA;
            end
            else
            begin
                sentence_kind_next = KIND_NONE;
            end
        end

        slot     = (pos >= POS_MAX) ? slot_of(sentence_kind_next, fnum0) : NO_SLOT;
        is_comma = (item.char_in == CHAR_COMMA);

        field_number_next = fnum0;
        field_offset_next = foff0;
        res_valid         = 1'b0;
        res.slot          = slot;
        res.offset        = 4'd0;
        res.char_out      = 8'd0;
        res.is_end        = 1'b0;
        res.length        = 4'd0;

        if (is_comma)
        begin
            if (pos != 3'd0)
            begin
                res_valid         = (slot != NO_SLOT);
                res.is_end        = 1'b1;
                res.length        = foff0;
                field_number_next = (fnum0 < FIELD_MAX) ? fnum0 + 4'd1 : fnum0;
                field_offset_next = 4'd0;
            end
        end
        else if (slot != NO_SLOT && foff0 < FIELD_CAP)
        begin
            res_valid         = 1'b1;
            res.offset        = foff0;
            res.char_out      = item.char_in;
            field_offset_next = foff0 + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 3'd0;
            sentence_kind_reg <= KIND_NONE;
            field_number_reg  <= 4'd0;
            field_offset_reg  <= 4'd0;
        end
        else if (fire)
        begin
            byte_position_reg <= byte_position_next;
            sentence_kind_reg <= sentence_kind_next;
            field_number_reg  <= field_number_next;
            field_offset_reg  <= field_offset_next;
        end
    end

    `NFE_ASSERT_ALWAYS(a_offset_cap, field_offset_reg <= FIELD_CAP)
    `NFE_ASSERT_ALWAYS(a_pos_sat, byte_position_reg <= POS_MAX)
    `NFE_ASSERT_IMPLY(a_kind_early, byte_position_reg <= POS_KIND, sentence_kind_reg == KIND_NONE)
    `NFE_ASSERT_IMPLY(a_res_late, fire && res_valid, byte_position_next == POS_MAX)

endmodule

/* sv/nfe_out_buf.sv */
// Result register with skid entry
`include "nmea_field_extractor_core_defines.svh"
module nfe_out_buf
    import nfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  nfe_result_t push_res,
    output logic        ready,
    output logic        out_valid,
    input  logic        out_stall,
    output nfe_result_t out_res
);

    logic        main_full_reg;
    logic        main_full_next;
    logic        skid_full_reg;
    logic        skid_full_next;
    nfe_result_t main_reg;
    nfe_result_t skid_reg;
    logic        pop;
    logic        load_main_push;
    logic        load_main_skid;
    logic        load_skid;

    assign ready = !skid_full_reg;
    assign pop   = main_full_reg && !out_stall;

    always_comb
    begin
        main_full_next = main_full_reg;
        skid_full_next = skid_full_reg;
        load_main_push = 1'b0;
        load_main_skid = 1'b0;
        load_skid      = 1'b0;
        if (!main_full_reg)
        begin
            main_full_next = push;
            load_main_push = push;
        end
        else if (pop)
        begin
            if (skid_full_reg)
            begin
                load_main_skid = 1'b1;
                skid_full_next = 1'b0;
            end
            else
            begin
                main_full_next = push;
                load_main_push = push;
            end
        end
        else if (push)
        begin
            skid_full_next = 1'b1;
            load_skid      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_full_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            main_full_reg <= main_full_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main_push)
        begin
            main_reg <= push_res;
        end
        else if (load_main_skid)
        begin
            main_reg <= skid_reg;
        end
        if (load_skid)
        begin
            skid_reg <= push_res;
        end
    end

    assign out_valid = main_full_reg;
    assign out_res   = main_reg;

    `NFE_ASSERT_IMPLY(a_skid_needs_main, skid_full_reg, main_full_reg)
    `NFE_ASSERT_IMPLY(a_no_push_full, push, !skid_full_reg)

endmodule

/* sv/nmea_field_extractor_core.sv */
// NMEA field extractor top level: input register, decode, result buffer
// A character waits in the input register, its result in the result register.
// Throughput: one character per clock while the skid entry is empty; it takes one
// more result under out_stall, so out_stall reaches in_stall only via registers.
// Reset (rst_n low, asynchronous): buffers empty, sentence state cleared as if
// a sentence began at reset.
module nmea_field_extractor_core
    import nfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       sentence_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] slot,
    output logic [3:0] offset,
    output logic [7:0] char_out,
    output logic       is_end,
    output logic [3:0] length
);

    nfe_item_t   item;
    nfe_item_t   held;
    logic        full;
    logic        advance;
    logic        buf_ready;
    logic        res_valid;
    nfe_result_t res;
    nfe_result_t out_res;

    assign item.char_in        = char_in;
    assign item.sentence_start = sentence_start;
    assign advance             = full && buf_ready;

    nfe_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item     (item),
        .advance  (advance),
        .full     (full),
        .held     (held)
    );

    nfe_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (held),
        .res_valid (res_valid),
        .res       (res)
    );

    nfe_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && res_valid),
        .push_res  (res),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign slot     = out_res.slot;
    assign offset   = out_res.offset;
    assign char_out = out_res.char_out;
    assign is_end   = out_res.is_end;
    assign length   = out_res.length;

endmodule

/* tb/tb_nmea_field_extractor_core.sv */
// Self-checking testbench for nmea_field_extractor_core with random RMC/GGA sentences and noise
`timescale 1ns / 1ps

module tb_nmea_field_extractor_core;
    import nfe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 20;

    localparam logic [3:0] FLD_RMC_LAST = 4'd6;
    localparam logic [3:0] FLD_DATE     = 4'd9;
    localparam logic [3:0] FLD_FIX      = 4'd6;
    localparam logic [3:0] FLD_SATS     = 4'd7;
    localparam logic [3:0] SLOT_DATE    = 4'd6;
    localparam logic [3:0] SLOT_FIX     = 4'd7;
    localparam logic [3:0] SLOT_SATS    = 4'd8;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       sentence_start;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] slot;
    logic [3:0] offset;
    logic [7:0] char_out;
    logic       is_end;
    logic [3:0] length;

    nmea_field_extractor_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .sentence_start (sentence_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot           (slot),
        .offset         (offset),
        .char_out       (char_out),
        .is_end         (is_end),
        .length         (length)
    );

    nfe_item_t   byte_queue[$];
    nfe_result_t expected_fields[$];
    nfe_result_t next_field;

    logic [2:0] cur_pos;
    kind_t      cur_kind;
    logic [3:0] cur_field;
    logic [3:0] cur_fill;

    int  send_idle_pct;
    int  stall_pct;
    bit  sender_hold;
    bit  tx_enable;
    bit  in_took;
    bit  hold_request;
    int  hold_left;
    int  cycle_count;
    int  mismatches;
    int  items_taken;
    int  results_checked;
    int  sentences_made;
    int  half_mark;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [3:0] wanted_slot(kind_t k, logic [3:0] f);
        logic [3:0] s;
        s = NO_SLOT;
        if (k == KIND_RMC)
        begin
            if (f >= 4'd1 && f <= FLD_RMC_LAST)
            begin
                s = f - 4'd1;
            end
            else if (f == FLD_DATE)
            begin
                s = SLOT_DATE;
            end
        end
        else if (k == KIND_GGA)
        begin
            if (f == FLD_FIX)
            begin
                s = SLOT_FIX;
            end
            else if (f == FLD_SATS)
            begin
                s = SLOT_SATS;
            end
        end
        return s;
    endfunction

    task automatic decode_byte(input logic [7:0] ch, input logic st);
        logic [2:0] p;
        logic [3:0] s;
        if (st)
        begin
            cur_pos   = 3'd0;
            cur_kind  = KIND_NONE;
            cur_field = 4'd0;
            cur_fill  = 4'd0;
        end
        p = cur_pos;
        if (cur_pos < POS_MAX)
        begin
            cur_pos = cur_pos + 3'd1;
        end
        if (p == POS_KIND)
        begin
            cur_kind = (ch == CHAR_M) ? KIND_RMC : ((ch == CHAR_G) ? KIND_GGA : KIND_NONE);
        end
        s = (p >= POS_MAX) ? wanted_slot(cur_kind, cur_field) : NO_SLOT;
        if (ch == CHAR_COMMA)
        begin
            // a comma at the very first byte is not a separator
            if (p != 3'd0)
            begin
                if (s != NO_SLOT)
                begin
                    expected_fields.push_back(nfe_result_t'{slot: s, offset: 4'd0,
                        char_out: 8'd0, is_end: 1'b1, length: cur_fill});
                end
                if (cur_field < FIELD_MAX)
                begin
                    cur_field = cur_field + 4'd1;
                end
                cur_fill = 4'd0;
            end
        end
        else if (s != NO_SLOT && cur_fill < FIELD_CAP)
        begin
            expected_fields.push_back(nfe_result_t'{slot: s, offset: cur_fill,
                char_out: ch, is_end: 1'b0, length: 4'd0});
            cur_fill = cur_fill + 4'd1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want_v, cycle_count);
        mismatches++;
    endtask

    task automatic put_byte(input logic [7:0] ch, input logic st);
        byte_queue.push_back(nfe_item_t'{char_in: ch, sentence_start: st});
    endtask

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(3) != 0)
        begin
            c = 8'($urandom_range(8'h2D, 8'h5A));
        end
        else
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CHAR_COMMA);
        end
        return c;
    endfunction

    task automatic send_sentence(input kind_t k, input logic st, inout int useful);
        int         nf;
        int         len;
        logic [7:0] tag;
        bit         wanted;
        sentences_made++;
        put_byte(CHAR_DOLLAR, st);
        put_byte(CHAR_G, 1'b0);
        put_byte(8'h50, 1'b0);
        case (k)
            KIND_RMC:
            begin
                put_byte(8'h52, 1'b0);
                put_byte(CHAR_M, 1'b0);
                put_byte(8'h43, 1'b0);
            end
            KIND_GGA:
            begin
                put_byte(CHAR_G, 1'b0);
                put_byte(CHAR_G, 1'b0);
                put_byte(8'h41, 1'b0);
            end
            default:
            begin
                put_byte(field_char(), 1'b0);
                do
                    tag = field_char();
                while (tag == CHAR_M || tag == CHAR_G);
                put_byte(tag, 1'b0);
                put_byte(field_char(), 1'b0);
            end
        endcase
        nf = $urandom_range(4, 17);
        for (int f = 1; f <= nf; f++)
        begin
            put_byte(CHAR_COMMA, 1'b0);
            len = ($urandom_range(7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 6);
            wanted = (k == KIND_RMC && (f <= FLD_RMC_LAST || f == FLD_DATE))
                  || (k == KIND_GGA && (f == FLD_FIX || f == FLD_SATS));
            if (wanted)
            begin
                useful += len + 1;
            end
            for (int i = 0; i < len; i++)
            begin
                put_byte(field_char(), 1'b0);
            end
        end
        if ($urandom_range(1) != 0)
        begin
            put_byte(CHAR_STAR, 1'b0);
            put_byte(field_char(), 1'b0);
            put_byte(field_char(), 1'b0);
            put_byte(CHAR_CR, 1'b0);
            put_byte(CHAR_LF, 1'b0);
        end
    endtask

    task automatic send_noise();
        int         n;
        logic [7:0] ch;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
        begin
            ch = ($urandom_range(3) == 0) ? CHAR_COMMA : 8'($urandom_range(255));
            put_byte(ch, $urandom_range(7) == 0);
        end
    endtask

    task automatic run_random(input int target);
        int useful;
        int r;
        useful = 0;
        while (useful < target)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                send_sentence(KIND_RMC, $urandom_range(9) != 0, useful);
            end
            else if (r < 80)
            begin
                send_sentence(KIND_GGA, $urandom_range(9) != 0, useful);
            end
            else if (r < 88)
            begin
                send_sentence(KIND_NONE, 1'b1, useful);
            end
            else
            begin
                send_noise();
            end
        end
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || in_valid || expected_fields.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!in_valid || in_took)
        begin
            if (tx_enable && !sender_hold && byte_queue.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid       <= 1'b1;
                char_in        <= byte_queue[0].char_in;
                sentence_start <= byte_queue[0].sentence_start;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own long hold-off counter
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // accepted items feed the decoder; accepted results are checked in order
    always @(posedge clk)
    begin
        in_took = 1'b0;
        if (rst_n && in_valid && !in_stall)
        begin
            decode_byte(char_in, sentence_start);
            void'(byte_queue.pop_front());
            in_took = 1'b1;
            items_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_fields.size() == 0)
            begin
                report_mismatch("unexpected result, slot", slot, -1);
            end
            else
            begin
                next_field = expected_fields.pop_front();
                if (slot !== next_field.slot)
                begin
                    report_mismatch("slot", slot, next_field.slot);
                end
                if (offset !== next_field.offset)
                begin
                    report_mismatch("offset", offset, next_field.offset);
                end
                if (char_out !== next_field.char_out)
                begin
                    report_mismatch("char_out", char_out, next_field.char_out);
                end
                if (is_end !== next_field.is_end)
                begin
                    report_mismatch("is_end", is_end, next_field.is_end);
                end
                if (length !== next_field.length)
                begin
                    report_mismatch("length", length, next_field.length);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout: %0d results still expected", expected_fields.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        char_in         = 8'd0;
        sentence_start  = 1'b0;
        out_stall       = 1'b0;
        cur_pos         = 3'd0;
        cur_kind        = KIND_NONE;
        cur_field       = 4'd0;
        cur_fill        = 4'd0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        sender_hold     = 1'b0;
        tx_enable       = 1'b0;
        in_took         = 1'b0;
        hold_request    = 1'b0;
        hold_left       = 0;
        cycle_count     = 0;
        mismatches      = 0;
        items_taken     = 0;
        results_checked = 0;
        sentences_made  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        tx_enable = 1'b1;

        // no start flag after reset; extreme bytes in an RMC time field
        put_byte(8'h78, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(8'h79, 1'b0);
        put_byte(8'h7A, 1'b0);
        put_byte(CHAR_M, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        // comma as first byte, commas before the kind byte, GGA fix and sats
        put_byte(CHAR_COMMA, 1'b1);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(CHAR_G, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        put_byte(8'h31, 1'b0);
        put_byte(8'h32, 1'b0);
        put_byte(CHAR_COMMA, 1'b0);
        drain();

        run_random(50);
        drain();

        send_idle_pct = 76;
        run_random(50);
        drain();

        send_idle_pct = 0;
        stall_pct     = 76;
        run_random(50);
        drain();

        // long receiver hold with the sender pushing, then a full drain pause
        stall_pct = 0;
        run_random(50);
        half_mark    = byte_queue.size() / 2;
        hold_request = 1'b1;
        while (hold_request || hold_left != 0)
        begin
            @(posedge clk);
        end
        send_idle_pct = 15;
        stall_pct     = 15;
        while (byte_queue.size() > half_mark)
        begin
            @(posedge clk);
        end
        sender_hold = 1'b1;
        while (in_valid || expected_fields.size() != 0)
        begin
            @(posedge clk);
        end
        sender_hold = 1'b0;
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run: %0d bytes over %0d generated sentences plus noise, %0d results checked",
                 items_taken, sentences_made, results_checked);
        $display("idling: none, sender, receiver, both; long output hold and a drain pause");
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
